// ===== design/epcd_pkg.sv =====
// Shared types and constants for the entropy pool ChaCha20 DRBG.
package epcd_pkg;

    localparam logic [31:0] C_SIGMA0 = 32'h61707865;
    localparam logic [31:0] C_SIGMA1 = 32'h3320646e;
    localparam logic [31:0] C_SIGMA2 = 32'h79622d32;
    localparam logic [31:0] C_SIGMA3 = 32'h6b206574;
    localparam logic [8:0]  C_COUNT_MAX  = 9'd256;
    localparam logic [8:0]  C_THRESH_RST = 9'd128;
    localparam int          C_QR_STEPS   = 80;
    localparam logic        C_REQ_ENTROPY = 1'b0;
    localparam logic        C_REQ_READ    = 1'b1;
    localparam logic [1:0]  C_ADDR_THRESH = 2'd0;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic load_ent;   // latch entropy item and stir
        logic reseed;     // load key/nonce from pool
        logic init_st;    // load working state
        logic qr_step;    // one quarter round
        logic finish;     // add input, advance counter
        logic load_out;   // present output beat
        logic [2:0] beat;
        logic ent_out;    // present entropy result
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic cont;
    } t_sts;

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

// ===== design/epcd_datapath.sv =====
// Datapath: pool, key/nonce/counter, shared quarter-round unit and output register.
module epcd_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  epcd_pkg::t_cmd       i_cmd,
    output epcd_pkg::t_sts       o_sts,
    input  logic [111:0]         i_in_tdata,
    input  logic                 i_in_tuser,
    input  logic                 i_in_tlast,
    input  logic [8:0]           i_thresh,
    output logic [63:0]          o_word,
    output logic                 o_last,
    output logic                 o_seeded,
    output logic                 o_just
);
    epcd_pkg::t_word r_pool [16];
    epcd_pkg::t_word r_key  [8];
    epcd_pkg::t_word r_nonce [3];
    epcd_pkg::t_word r_ctr;
    epcd_pkg::t_word r_st   [16];
    logic [8:0]  r_count;
    logic [2:0]  r_qi;
    logic [63:0] r_word;
    logic        r_last, r_seeded, r_just;

    logic        w_req, w_bend, w_cont;
    epcd_pkg::t_word w_ent;
    logic [8:0]  w_credit;
    logic [63:0] w_ts;
    assign w_req    = i_in_tuser;
    assign w_ent    = i_in_tdata[31:0];
    assign w_credit = i_in_tdata[40:32];
    assign w_bend   = i_in_tlast;
    assign w_ts     = i_in_tdata[104:41];
    assign w_cont   = i_in_tdata[105];
    assign o_sts.is_read = (w_req == epcd_pkg::C_REQ_READ);
    assign o_sts.cont    = w_cont;

    // quarter-round index selection
    logic [3:0] a, b, c, d;
    logic       diag;
    assign diag = r_qi[2];
    always_comb begin
        a = {2'b00, r_qi[1:0]};
        b = diag ? {2'b01, r_qi[1:0] + 2'd1} : {2'b01, r_qi[1:0]};
        c = diag ? {2'b10, r_qi[1:0] + 2'd2} : {2'b10, r_qi[1:0]};
        d = diag ? {2'b11, r_qi[1:0] + 2'd3} : {2'b11, r_qi[1:0]};
    end

    epcd_pkg::t_word qa, qb, qc, qd, ta, tb, tc, td;
    always_comb begin
        ta = r_st[a] + r_st[b];
        td = epcd_pkg::rotl(r_st[d] ^ ta, 16);
        tc = r_st[c] + td;
        tb = epcd_pkg::rotl(r_st[b] ^ tc, 12);
        qa = ta + tb;
        qd = epcd_pkg::rotl(td ^ qa, 8);
        qc = tc + qd;
        qb = epcd_pkg::rotl(tb ^ qc, 7);
    end

    function automatic epcd_pkg::t_word init_word(input int i,
        input epcd_pkg::t_word key[8], input epcd_pkg::t_word ctr,
        input epcd_pkg::t_word nn[3]);
        epcd_pkg::t_word v;
        case (i)
            0: v = epcd_pkg::C_SIGMA0;
            1: v = epcd_pkg::C_SIGMA1;
            2: v = epcd_pkg::C_SIGMA2;
            3: v = epcd_pkg::C_SIGMA3;
            12: v = ctr;
            13: v = nn[0];
            14: v = nn[1];
            15: v = nn[2];
            default: v = key[(i - 4) % 8];
        endcase
        return v;
    endfunction

    // entropy stir
    logic [3:0] idx, i3, i13;
    epcd_pkg::t_word stir;
    logic [9:0] sum;
    logic [8:0] nxt;
    assign idx = r_count[3:0];
    assign i3  = idx + 4'd3;
    assign i13 = idx + 4'd13;
    assign stir = r_pool[idx] ^ w_ent;
    assign sum = {1'b0, r_count} + {1'b0, w_credit};
    assign nxt = !w_bend ? r_count :
                 (sum > {1'b0, epcd_pkg::C_COUNT_MAX}) ? epcd_pkg::C_COUNT_MAX : sum[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_pool[i] <= '0;
            for (int i = 0; i < 8; i++)  r_key[i]  <= '0;
            for (int i = 0; i < 3; i++)  r_nonce[i] <= '0;
            r_ctr   <= '0;
            r_count <= '0;
            r_qi    <= '0;
        end else begin
            if (i_cmd.load_ent) begin
                // taps read after own-word xor when idx+3 or idx+13 == idx never happens
                r_pool[idx] <= stir ^ epcd_pkg::rotl(r_pool[i3], 7)
                                    ^ epcd_pkg::rotl(r_pool[i13], 19);
                r_count <= nxt;
                r_word   <= '0;
                r_last   <= 1'b1;
                r_seeded <= (nxt >= i_thresh);
                r_just   <= (r_count < i_thresh) && (nxt >= i_thresh);
            end
            if (i_cmd.reseed) begin
                for (int i = 0; i < 8; i++) r_key[i] <= r_pool[i] ^ r_pool[i + 8];
                r_nonce[0] <= w_ts[31:0];
                r_nonce[1] <= w_ts[63:32];
                r_nonce[2] <= r_pool[15] ^ r_pool[0];
                r_ctr <= '0;
            end
            if (i_cmd.init_st) begin
                for (int i = 0; i < 16; i++) r_st[i] <= init_word(i, r_key, r_ctr, r_nonce);
                r_qi <= '0;
            end
            if (i_cmd.qr_step) begin
                r_st[a] <= qa; r_st[b] <= qb; r_st[c] <= qc; r_st[d] <= qd;
                r_qi <= r_qi + 3'd1;
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < 16; i++)
                    r_st[i] <= r_st[i] + init_word(i, r_key, r_ctr, r_nonce);
                r_ctr <= r_ctr + 32'd1;
                if (r_ctr == '1) r_nonce[0] <= r_nonce[0] + 32'd1;
            end
            if (i_cmd.load_out) begin
                r_word   <= {r_st[{i_cmd.beat, 1'b1}], r_st[{i_cmd.beat, 1'b0}]};
                r_last   <= (i_cmd.beat == 3'd7);
                r_seeded <= (r_count >= i_thresh);
                r_just   <= 1'b0;
            end
        end
    end

    assign o_word   = r_word;
    assign o_last   = r_last;
    assign o_seeded = r_seeded;
    assign o_just   = r_just;
endmodule

// ===== design/epcd_ctrl.sv =====
// Controller: sequences stir, reseed, 80 quarter rounds and the output beats (eight per read, one per entropy item).
module epcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  epcd_pkg::t_sts  i_sts,
    output epcd_pkg::t_cmd  o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_ROUND = 6'b000100,
        S_FIN   = 6'b001000,
        S_LOAD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic [2:0] r_beat, n_beat;
    logic       w_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_beat  = r_beat;
        o_cmd   = '0;
        o_cmd.beat = r_beat;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_sts.is_read) begin
                        o_cmd.reseed = !i_sts.cont;
                        n_state = S_INIT;
                    end else begin
                        o_cmd.load_ent = 1'b1;
                        n_beat = 3'd7;
                        n_state = S_OUT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_st = 1'b1;
                n_cnt = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.qr_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(epcd_pkg::C_QR_STEPS - 1)) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_beat = '0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_beat == 3'd7) n_state = S_IDLE;
                    else begin
                        n_beat = r_beat + 3'd1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_beat  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_beat  <= n_beat;
        end
    end

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |-> r_cnt < 7'(epcd_pkg::C_QR_STEPS)) else $error("round count");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready) else $error("accept while busy");
    a_fin_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> $past(r_state) == S_ROUND) else $error("finish order");
endmodule

// ===== design/entropy_pool_chacha20_drbg_unit.sv =====
// Top level of the entropy pool ChaCha20 DRBG.
//  channel  dir  beat contents
//  s_axis   in   one entropy or read item
//  m_axis   out  one 64-bit result (1 per entropy item, 8 per read)
//  apb      cfg  seed_threshold at address 0
// Entropy item: accepted, result shown the next cycle.
// Read item: accepted, then init, 80 quarter rounds on one shared unit and finish,
// then a load and a present step for each of the eight output beats.
// Input is taken only while idle; output stalls hold the sequence.
// Reset is synchronous, clears pool, key, nonce and counter, threshold back to 128.
module entropy_pool_chacha20_drbg_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entropy_word[31:0], credit_bits[40:32], timestamp[104:41],
    // continue_read[105], zero[111:106]
    input  logic [111:0] s_axis_tdata,
    // buffer_end
    input  logic         s_axis_tlast,
    // req_type[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // random_word[63:0]
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // seeded[0], just_seeded[1]
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    epcd_pkg::t_cmd w_cmd;
    epcd_pkg::t_sts w_sts;
    logic [8:0] r_thresh;

    assign pready = 1'b1;
    assign prdata = (paddr == epcd_pkg::C_ADDR_THRESH) ? {23'd0, r_thresh} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= epcd_pkg::C_THRESH_RST;
        end else if (psel && penable && pwrite && paddr == epcd_pkg::C_ADDR_THRESH) begin
            r_thresh <= pwdata[8:0];
        end
    end

    epcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    epcd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_tdata (s_axis_tdata),
        .i_in_tuser (s_axis_tuser),
        .i_in_tlast (s_axis_tlast),
        .i_thresh   (r_thresh),
        .o_word     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_seeded   (m_axis_tuser[0]),
        .o_just     (m_axis_tuser[1])
    );
endmodule

// ===== tb/entropy_pool_chacha20_drbg_unit_tb.sv =====
// Testbench for the entropy pool ChaCha20 DRBG: predicts each result beat and checks it.
module entropy_pool_chacha20_drbg_unit_tb;

    typedef struct packed {
        logic [63:0] rnd;
        logic        last;
        logic        seeded;
        logic        just_seeded;
    } t_beat;

    typedef struct packed {
        logic         req;
        logic         bend;
        logic [111:0] data;
    } t_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic [1:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    entropy_pool_chacha20_drbg_unit DUT (.*);

    // predictor state
    logic [31:0] m_pool [16];
    logic [8:0]  m_count;
    logic [31:0] m_key [8];
    logic [31:0] m_ctr;
    logic [31:0] m_nonce [3];
    logic [8:0]  m_thresh;

    t_item        send_q [$];
    t_beat        expected_q [$];
    int           errors;
    int           beats_seen;
    int           reads_sent;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void qround(ref logic [31:0] s [16], input int a, input int b,
                                   input int c, input int d);
        s[a] = s[a] + s[b]; s[d] = rl(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rl(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rl(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rl(s[b] ^ s[c], 7);
    endfunction

    // compute expected result beats for one accepted item
    task automatic predict_item(input logic req, input logic bend, input logic [111:0] d);
        logic [31:0] init [16];
        logic [31:0] w [16];
        logic [31:0] word;
        logic [8:0]  credit;
        logic [9:0]  nxt;
        logic [63:0] ts;
        int          idx;
        t_beat       b;
        if (req == epcd_pkg::C_REQ_ENTROPY) begin
            word = d[31:0];
            credit = d[40:32];
            idx = m_count % 16;
            nxt = {1'b0, m_count};
            m_pool[idx] = m_pool[idx] ^ word;
            m_pool[idx] = m_pool[idx] ^ rl(m_pool[(idx + 3) % 16], 7);
            m_pool[idx] = m_pool[idx] ^ rl(m_pool[(idx + 13) % 16], 19);
            if (bend) begin
                nxt = {1'b0, m_count} + {1'b0, credit};
                if (nxt > {1'b0, epcd_pkg::C_COUNT_MAX}) nxt = {1'b0, epcd_pkg::C_COUNT_MAX};
            end
            b.rnd = '0;
            b.last = 1'b1;
            b.seeded = nxt >= {1'b0, m_thresh};
            b.just_seeded = (m_count < m_thresh) && (nxt >= {1'b0, m_thresh});
            m_count = nxt[8:0];
            expected_q.push_back(b);
        end else begin
            ts = d[104:41];
            if (!d[105]) begin
                for (int k = 0; k < 8; k++) m_key[k] = m_pool[k] ^ m_pool[k + 8];
                m_nonce[0] = ts[31:0];
                m_nonce[1] = ts[63:32];
                m_nonce[2] = m_pool[15] ^ m_pool[0];
                m_ctr = '0;
            end
            init[0] = epcd_pkg::C_SIGMA0; init[1] = epcd_pkg::C_SIGMA1;
            init[2] = epcd_pkg::C_SIGMA2; init[3] = epcd_pkg::C_SIGMA3;
            for (int k = 0; k < 8; k++) init[4 + k] = m_key[k];
            init[12] = m_ctr; init[13] = m_nonce[0];
            init[14] = m_nonce[1]; init[15] = m_nonce[2];
            w = init;
            for (int r = 0; r < 10; r++) begin
                qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
                qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
                qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
                qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
            end
            for (int k = 0; k < 16; k++) w[k] = w[k] + init[k];
            m_ctr = m_ctr + 32'd1;
            if (m_ctr == '0) m_nonce[0] = m_nonce[0] + 32'd1;
            for (int k = 0; k < 8; k++) begin
                b.rnd = {w[2 * k + 1], w[2 * k]};
                b.last = (k == 7);
                b.seeded = m_count >= m_thresh;
                b.just_seeded = 1'b0;
                expected_q.push_back(b);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", beats_seen, what, got, want);
        errors++;
    endtask

    function automatic t_item ent_item(input logic [31:0] w, input logic [8:0] c,
                                       input logic e);
        t_item d;
        d = '0;
        d.req = epcd_pkg::C_REQ_ENTROPY;
        d.bend = e;
        d.data[31:0] = w;
        d.data[40:32] = c;
        d.data[104:41] = {$urandom, $urandom};
        d.data[105] = 1'($urandom_range(0, 1));
        return d;
    endfunction

    function automatic t_item read_item(input logic [63:0] ts, input logic c);
        t_item d;
        d = '0;
        d.req = epcd_pkg::C_REQ_READ;
        d.bend = 1'($urandom_range(0, 1));
        d.data[31:0] = $urandom;
        d.data[40:32] = 9'($urandom_range(0, 511));
        d.data[104:41] = ts;
        d.data[105] = c;
        return d;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) void'(send_q.pop_front());
            if (send_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= send_q[0].data;
                s_axis_tlast <= send_q[0].bend;
                s_axis_tuser <= send_q[0].req;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_item(s_axis_tuser, s_axis_tlast, s_axis_tdata);
            if (s_axis_tuser == epcd_pkg::C_REQ_READ) reads_sent++;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (hold_cycles > 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= $urandom_range(0, 99) >= snk_idle_pct;
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("UNEXPECTED beat %0d data %h", beats_seen, m_axis_tdata);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_axis_tdata !== e.rnd) report_mismatch("random_word", m_axis_tdata, e.rnd);
                if (m_axis_tlast !== e.last)
                    report_mismatch("last", 64'(m_axis_tlast), 64'(e.last));
                if (m_axis_tuser[0] !== e.seeded)
                    report_mismatch("seeded", 64'(m_axis_tuser[0]), 64'(e.seeded));
                if (m_axis_tuser[1] !== e.just_seeded)
                    report_mismatch("just_seeded", 64'(m_axis_tuser[1]),
                                    64'(e.just_seeded));
            end
            beats_seen++;
        end
    end

    task automatic drain();
        while (send_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_thresh(input logic [8:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= epcd_pkg::C_ADDR_THRESH; pwdata <= {23'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_thresh = v;
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_q.push_back(ent_item($urandom, 9'($urandom_range(0, 511)),
                                          $urandom_range(0, 3) == 0));
            end else if (r < 80) begin
                send_q.push_back(read_item({$urandom, $urandom}, 1'b0));
            end else begin
                send_q.push_back(read_item({$urandom, $urandom}, 1'b1));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; beats_seen = 0; reads_sent = 0; hold_cycles = 0;
        src_idle_pct = 33; snk_idle_pct = 72;
        foreach (m_pool[k]) m_pool[k] = '0;
        foreach (m_key[k]) m_key[k] = '0;
        foreach (m_nonce[k]) m_nonce[k] = '0;
        m_count = '0; m_ctr = '0; m_thresh = epcd_pkg::C_THRESH_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unseeded read, extremes, credit edge cases, continues
        send_q.push_back(read_item('0, 1'b1));
        send_q.push_back(read_item('1, 1'b0));
        send_q.push_back(ent_item('1, 9'd511, 1'b0));
        send_q.push_back(ent_item('0, 9'd0, 1'b1));
        send_q.push_back(ent_item(32'hdeadbeef, 9'd127, 1'b1));
        send_q.push_back(ent_item(32'h12345678, 9'd1, 1'b1));
        send_q.push_back(ent_item(32'h80000001, 9'd1, 1'b1));
        send_q.push_back(ent_item('1, 9'd511, 1'b1));
        send_q.push_back(ent_item(32'h5a5a5a5a, 9'd256, 1'b1));
        send_q.push_back(read_item(64'h0123456789abcdef, 1'b0));
        send_q.push_back(read_item('0, 1'b1));
        send_q.push_back(read_item('1, 1'b1));
        drain();

        // zero threshold, then unreachable threshold with a receiver hold-off
        write_thresh(9'd0);
        send_q.push_back(ent_item($urandom, 9'd5, 1'b1));
        send_q.push_back(read_item({$urandom, $urandom}, 1'b0));
        random_phase(40);
        drain();
        write_thresh(9'd511);
        hold_cycles <= 400;
        random_phase(40);
        drain();
        write_thresh(9'd256);
        src_idle_pct = 72; snk_idle_pct = 33;
        random_phase(50);
        drain();
        write_thresh(9'd200);
        src_idle_pct = 0; snk_idle_pct = 0;
        random_phase(70);
        drain();

        $display("covered %0d reads and %0d result beats over five threshold settings",
                 reads_sent, beats_seen);
        if (errors == 0) $display("entropy_pool_chacha20_drbg_unit_tb passed");
        else $display("entropy_pool_chacha20_drbg_unit_tb failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout");
        $display("entropy_pool_chacha20_drbg_unit_tb failed");
        $finish;
    end

endmodule
